>>> hw/rtl/brhp_pkg.sv
// Shared types and constants for the byte-range header parser.
// No dependencies; used by every other file of the block.
package brhp_pkg;

  localparam int VALUE_BITS_DEF = 63;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int POS_BITS       = 63;
  localparam int PFX_LEN        = 6;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // "bytes="
  localparam logic [7:0] PREFIX_TEXT [PFX_LEN] = '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3d};

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_PREFIX  = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic               last;
    logic               is_digit;
    logic [3:0]         digit;
    logic               is_dash;
    logic               is_delim;
    logic               is_nul;
    logic [PFX_LEN-1:0] pfx_hit;
  } brhp_tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brhp_fifo_sts_t;

endpackage

>>> hw/rtl/brhp_if.sv
// Valid/ready channel interfaces of the byte-range header parser.
// Depends on brhp_pkg for the position width.
interface brhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface brhp_res_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [brhp_pkg::POS_BITS-1:0] range_first;
  logic [brhp_pkg::POS_BITS-1:0] range_last;

  modport source (output valid, status, range_first, range_last, input ready);
  modport sink   (input valid, status, range_first, range_last, output ready);
endinterface

>>> hw/rtl/byte_range_header_parser.sv
// Byte-range header parser top level: classifier, token queue, parser back end.
// Depends on brhp_pkg, brhp_if, brhp_front, brhp_fifo and brhp_back.
//
// Usage:
//   byte_i carries one character of an HTTP Range header value per word, with
//   last_byte set on the final character. res_o carries one word per header:
//   status, range_first and range_last (positions are zero unless status is ok).
//   cfg_we_i/cfg_wdata_i write the resource length, which fills in an omitted
//   last position; write it only while no header is in flight.
// Timing:
//   One character per cycle sustained while no result is held on res_o. The
//   final character is written into the token queue, then popped into the back
//   end, whose result register loads the result word. The parse state update
//   (multiply by ten as shift-add, then the start/end compare) sets the
//   per-character cycle.
// Reset clears the parse state, the queue and the resource length (to zero).
// When res_o.ready is low with a result valid, the back end holds it, the token
// queue fills up to FIFO_DEPTH characters and then byte_i.ready drops.
module byte_range_header_parser #(
  parameter int VALUE_BITS = brhp_pkg::VALUE_BITS_DEF,
  parameter int FIFO_DEPTH = brhp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brhp_pkg::POS_BITS-1:0] cfg_wdata_i,
  brhp_byte_if.sink                     byte_i,
  brhp_res_if.source                    res_o
);

  brhp_pkg::brhp_tok_t      tok_in;
  brhp_pkg::brhp_tok_t      tok_out;
  brhp_pkg::brhp_fifo_sts_t fifo_sts;
  logic                     push;
  logic                     pop;

  brhp_front u_front (
    .byte_i     (byte_i),
    .fifo_sts_i (fifo_sts),
    .push_o     (push),
    .tok_o      (tok_in)
  );

  brhp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (tok_in),
    .pop_i  (pop),
    .tok_o  (tok_out),
    .sts_o  (fifo_sts)
  );

  brhp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_sts_i  (fifo_sts),
    .tok_i       (tok_out),
    .pop_o       (pop),
    .res_o       (res_o)
  );

  a_err_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != brhp_pkg::ST_OK) |->
      (res_o.range_first == '0 && res_o.range_last == '0))
    else $error("nonzero positions on error result");

  a_ok_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == brhp_pkg::ST_OK) |->
      (res_o.range_first <= res_o.range_last))
    else $error("ok result with start above end");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_sts.empty)
    else $error("token queue empty after push");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_sts.empty)
    else $error("pop from empty token queue");

endmodule

>>> hw/rtl/brhp_front.sv
// Front end: accepts header bytes and classifies each into a token.
// Depends on brhp_pkg and brhp_byte_if.
module brhp_front (
  brhp_byte_if.sink                 byte_i,
  input  brhp_pkg::brhp_fifo_sts_t  fifo_sts_i,
  output logic                      push_o,
  output brhp_pkg::brhp_tok_t       tok_o
);

  logic [7:0] c;
  logic [7:0] c_off;

  assign byte_i.ready = !fifo_sts_i.full;
  assign push_o       = byte_i.valid && !fifo_sts_i.full;
  assign c            = byte_i.text_byte;
  assign c_off        = c - brhp_pkg::CH_ZERO;

  always_comb begin
    tok_o.last     = byte_i.last_byte;
    tok_o.is_digit = (c >= brhp_pkg::CH_ZERO) && (c <= brhp_pkg::CH_NINE);
    tok_o.digit    = c_off[3:0];
    tok_o.is_dash  = (c == brhp_pkg::CH_DASH);
    tok_o.is_delim = (c == brhp_pkg::CH_COMMA) || (c == brhp_pkg::CH_AMP) ||
                     (c == brhp_pkg::CH_SEMI);
    tok_o.is_nul   = (c == brhp_pkg::CH_NUL);
    for (int k = 0; k < brhp_pkg::PFX_LEN; k++) begin
      tok_o.pfx_hit[k] = (c == brhp_pkg::PREFIX_TEXT[k]);
    end
  end

endmodule

>>> hw/rtl/brhp_fifo.sv
// Token queue between the classifier and the parser back end.
// Depends on brhp_pkg.
module brhp_fifo #(
  parameter int DEPTH = brhp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  brhp_pkg::brhp_tok_t       tok_i,
  input  logic                      pop_i,
  output brhp_pkg::brhp_tok_t       tok_o,
  output brhp_pkg::brhp_fifo_sts_t  sts_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  brhp_pkg::brhp_tok_t mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign sts_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.empty = (cnt_q == '0);
  assign do_push     = push_i && !sts_o.full;
  assign do_pop      = pop_i && !sts_o.empty;
  assign tok_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

>>> hw/rtl/brhp_back.sv
// Back end: prefix search, range state machine, result register.
// Depends on brhp_pkg and brhp_res_if.
module brhp_back #(
  parameter int VALUE_BITS = brhp_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brhp_pkg::POS_BITS-1:0] cfg_wdata_i,
  input  brhp_pkg::brhp_fifo_sts_t      fifo_sts_i,
  input  brhp_pkg::brhp_tok_t           tok_i,
  output logic                          pop_o,
  brhp_res_if.source                    res_o
);

  localparam int PB = brhp_pkg::POS_BITS;
  localparam int AW = VALUE_BITS + 4;

  typedef enum logic [2:0] {
    PH_START,
    PH_FIRST,
    PH_LAST,
    PH_LAST_N,
    PH_DONE
  } phase_e;

  phase_e                phase_q, phase_d, phase_n;
  logic [2:0]            pm_q, pm_d, pm_n;
  logic [VALUE_BITS-1:0] first_q, first_d, first_n;
  logic [PB-1:0]         last_q, last_d, last_n;
  logic [2:0]            err_q, err_d, err_n;
  logic [PB-1:0]         clm1_q, clm1_d;
  logic                  cl_zero_q, cl_zero_d;

  logic                  ovalid_q, ovalid_d;
  logic [2:0]            ostat_q, ostat_d;
  logic [PB-1:0]         ofirst_q, ofirst_d;
  logic [PB-1:0]         olast_q, olast_d;

  logic [VALUE_BITS-1:0] acc_base;
  logic [AW-1:0]         acc_ext;
  logic [AW-1:0]         acc_sum;
  logic                  acc_ovf;
  logic [2:0]            fin_st;
  logic [PB-1:0]         fin_last;

  assign pop_o             = !fifo_sts_i.empty && (!ovalid_q || res_o.ready);
  assign res_o.valid       = ovalid_q;
  assign res_o.status      = ostat_q;
  assign res_o.range_first = ofirst_q;
  assign res_o.range_last  = olast_q;

  // value * 10 + digit as shift-add, four bits wider range exposes overflow
  assign acc_base = (phase_q == PH_LAST_N) ? last_q[VALUE_BITS-1:0] : first_q;
  assign acc_ext  = {4'b0000, acc_base};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, tok_i.digit};
  assign acc_ovf  = |acc_sum[AW-1:VALUE_BITS];

  always_comb begin
    pm_n    = pm_q;
    phase_n = phase_q;
    first_n = first_q;
    last_n  = last_q;
    err_n   = err_q;

    if (err_q == brhp_pkg::ST_OK) begin
      if (pm_q < 3'(brhp_pkg::PFX_LEN)) begin
        if (tok_i.pfx_hit[pm_q]) begin
          pm_n = pm_q + 3'd1;
        end else if (tok_i.is_nul) begin
          err_n = brhp_pkg::ST_NO_PREFIX;
        end else if (tok_i.pfx_hit[0]) begin
          pm_n = 3'd1;
        end else begin
          pm_n = 3'd0;
        end
      end else begin
        case (phase_q)
          PH_START, PH_FIRST: begin
            if (tok_i.is_dash) begin
              phase_n = PH_LAST;
            end else if (!tok_i.is_digit) begin
              err_n = brhp_pkg::ST_BAD_CHAR;
            end else begin
              phase_n = PH_FIRST;
              if (acc_ovf) begin
                err_n = brhp_pkg::ST_OVERFLOW;
              end else begin
                first_n = acc_sum[VALUE_BITS-1:0];
              end
            end
          end
          PH_LAST: begin
            if (tok_i.is_delim) begin
              phase_n = PH_DONE;
              if (cl_zero_q) begin
                err_n = brhp_pkg::ST_INCOMPLETE;
              end else begin
                last_n = clm1_q;
              end
            end else if (!tok_i.is_digit) begin
              err_n = brhp_pkg::ST_BAD_CHAR;
            end else begin
              last_n  = PB'(tok_i.digit);
              phase_n = PH_LAST_N;
            end
          end
          PH_LAST_N: begin
            if (tok_i.is_delim) begin
              phase_n = PH_DONE;
            end else if (!tok_i.is_digit) begin
              err_n = brhp_pkg::ST_BAD_CHAR;
            end else if (acc_ovf) begin
              err_n = brhp_pkg::ST_OVERFLOW;
            end else begin
              last_n = PB'(acc_sum[VALUE_BITS-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
    end

    // end-of-text checks on the updated state
    fin_last = (phase_n == PH_LAST) ? clm1_q : last_n;
    if (err_n != brhp_pkg::ST_OK) begin
      fin_st = err_n;
    end else if (pm_n < 3'(brhp_pkg::PFX_LEN)) begin
      fin_st = brhp_pkg::ST_NO_PREFIX;
    end else if (phase_n == PH_LAST && cl_zero_q) begin
      fin_st = brhp_pkg::ST_INCOMPLETE;
    end else if (phase_n != PH_LAST && phase_n != PH_LAST_N && phase_n != PH_DONE) begin
      fin_st = brhp_pkg::ST_INCOMPLETE;
    end else if (PB'(first_n) > fin_last) begin
      fin_st = brhp_pkg::ST_INCOMPLETE;
    end else begin
      fin_st = brhp_pkg::ST_OK;
    end

    pm_d     = pm_q;
    phase_d  = phase_q;
    first_d  = first_q;
    last_d   = last_q;
    err_d    = err_q;
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    ofirst_d = ofirst_q;
    olast_d  = olast_q;

    if (res_o.ready) begin
      ovalid_d = 1'b0;
    end

    if (pop_o) begin
      if (tok_i.last) begin
        pm_d     = 3'd0;
        phase_d  = PH_START;
        first_d  = '0;
        last_d   = '0;
        err_d    = brhp_pkg::ST_OK;
        ovalid_d = 1'b1;
        ostat_d  = fin_st;
        ofirst_d = (fin_st == brhp_pkg::ST_OK) ? PB'(first_n) : '0;
        olast_d  = (fin_st == brhp_pkg::ST_OK) ? fin_last : '0;
      end else begin
        pm_d    = pm_n;
        phase_d = phase_n;
        first_d = first_n;
        last_d  = last_n;
        err_d   = err_n;
      end
    end

    clm1_d    = clm1_q;
    cl_zero_d = cl_zero_q;
    if (cfg_we_i) begin
      clm1_d    = cfg_wdata_i - 1'b1;
      cl_zero_d = (cfg_wdata_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q      <= 3'd0;
      phase_q   <= PH_START;
      first_q   <= '0;
      last_q    <= '0;
      err_q     <= brhp_pkg::ST_OK;
      clm1_q    <= '0;
      cl_zero_q <= 1'b1;
      ovalid_q  <= 1'b0;
      ostat_q   <= brhp_pkg::ST_OK;
      ofirst_q  <= '0;
      olast_q   <= '0;
    end else begin
      pm_q      <= pm_d;
      phase_q   <= phase_d;
      first_q   <= first_d;
      last_q    <= last_d;
      err_q     <= err_d;
      clm1_q    <= clm1_d;
      cl_zero_q <= cl_zero_d;
      ovalid_q  <= ovalid_d;
      ostat_q   <= ostat_d;
      ofirst_q  <= ofirst_d;
      olast_q   <= olast_d;
    end
  end

endmodule

>>> tb/tb_byte_range_header_parser.sv
// Testbench for byte_range_header_parser: directed and random Range header
// text, checked word by word against a built-in parse model.
// Depends on brhp_pkg, brhp_if and the RTL of the block.
module tb_byte_range_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS    = brhp_pkg::POS_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_START, PH_FIRST, PH_DASH, PH_LAST_DIG, PH_DONE
  } parse_ph_e;

  typedef struct packed {
    logic [2:0]          status;
    logic [POS_BITS-1:0] rng_first;
    logic [POS_BITS-1:0] rng_last;
  } range_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [POS_BITS-1:0] cfg_wdata;

  brhp_byte_if byte_ch ();
  brhp_res_if  res_ch ();

  byte_range_header_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_ch),
    .res_o       (res_ch)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // parse model state
  logic [POS_BITS-1:0] content_len;
  int unsigned         pfx_cnt;
  parse_ph_e           parse_ph;
  logic [63:0]         first_pos;
  logic [63:0]         last_pos;
  logic [2:0]          err_st;

  range_res_t  pending_ranges[$];
  range_res_t  want;
  logic [7:0]  hdr_chars[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  task automatic clear_parse();
    pfx_cnt   = 0;
    parse_ph  = PH_START;
    first_pos = '0;
    last_pos  = '0;
    err_st    = brhp_pkg::ST_OK;
  endtask

  function automatic bit push_digit(inout logic [63:0] v, input logic [3:0] d);
    logic [63:0] maxv;
    maxv = {1'b0, POS_MAX};
    if (v > (maxv - d) / 10) return 1'b0;
    v = v * 10 + d;
    return 1'b1;
  endfunction

  task automatic fill_last();
    if (content_len == '0) begin
      err_st = brhp_pkg::ST_INCOMPLETE;
    end else begin
      last_pos = {1'b0, content_len - 1'b1};
    end
    parse_ph = PH_DONE;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic       digit;
    logic       delim;
    logic [3:0] d;
    digit = (c >= brhp_pkg::CH_ZERO) && (c <= brhp_pkg::CH_NINE);
    delim = (c == brhp_pkg::CH_COMMA) || (c == brhp_pkg::CH_AMP) ||
            (c == brhp_pkg::CH_SEMI);
    d     = 4'(c - brhp_pkg::CH_ZERO);
    case (parse_ph)
      PH_START, PH_FIRST: begin
        if (c == brhp_pkg::CH_DASH) begin
          parse_ph = PH_DASH;
        end else if (!digit) begin
          err_st = brhp_pkg::ST_BAD_CHAR;
        end else begin
          if (parse_ph == PH_START) first_pos = '0;
          parse_ph = PH_FIRST;
          if (!push_digit(first_pos, d)) err_st = brhp_pkg::ST_OVERFLOW;
        end
      end
      PH_DASH: begin
        if (delim) begin
          fill_last();
        end else if (!digit) begin
          err_st = brhp_pkg::ST_BAD_CHAR;
        end else begin
          last_pos = 64'(d);
          parse_ph = PH_LAST_DIG;
        end
      end
      PH_LAST_DIG: begin
        if (delim) parse_ph = PH_DONE;
        else if (!digit) err_st = brhp_pkg::ST_BAD_CHAR;
        else if (!push_digit(last_pos, d)) err_st = brhp_pkg::ST_OVERFLOW;
      end
      default: ;
    endcase
  endtask

  // model one accepted word; the marked last word yields an expected range
  task automatic take_char(input logic [7:0] c, input logic fin);
    range_res_t r;
    logic [2:0] st;
    if (err_st == brhp_pkg::ST_OK) begin
      if (pfx_cnt < brhp_pkg::PFX_LEN) begin
        if (c == brhp_pkg::PREFIX_TEXT[pfx_cnt]) pfx_cnt++;
        else if (c == brhp_pkg::CH_NUL) err_st = brhp_pkg::ST_NO_PREFIX;
        else if (c == brhp_pkg::PREFIX_TEXT[0]) pfx_cnt = 1;
        else pfx_cnt = 0;
      end else begin
        parse_char(c);
      end
    end
    if (fin) begin
      st = err_st;
      if (st == brhp_pkg::ST_OK) begin
        if (pfx_cnt < brhp_pkg::PFX_LEN) begin
          st = brhp_pkg::ST_NO_PREFIX;
        end else begin
          if (parse_ph == PH_DASH) fill_last();
          if (err_st != brhp_pkg::ST_OK) st = err_st;
          else if (parse_ph != PH_LAST_DIG && parse_ph != PH_DONE)
            st = brhp_pkg::ST_INCOMPLETE;
          else if (first_pos > last_pos) st = brhp_pkg::ST_INCOMPLETE;
        end
      end
      r.status    = st;
      r.rng_first = (st == brhp_pkg::ST_OK) ? first_pos[POS_BITS-1:0] : '0;
      r.rng_last  = (st == brhp_pkg::ST_OK) ? last_pos[POS_BITS-1:0] : '0;
      pending_ranges.push_back(r);
      clear_parse();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= c;
    byte_ch.last_byte <= fin;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    take_char(c, fin);
  endtask

  task automatic send_header();
    foreach (hdr_chars[i]) send_char(hdr_chars[i], i == hdr_chars.size() - 1);
    hdr_chars.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_chars.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_header();
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [POS_BITS-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    content_len = v;
  endtask

  task automatic add_digits();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(1, 4);
    else if (r < 90) n = $urandom_range(5, 18);
    else n = $urandom_range(19, 21);
    repeat (n) hdr_chars.push_back(brhp_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic make_random_header();
    string       junk_set;
    logic [7:0]  delims[3];
    int unsigned kind;
    junk_set = "bybytes=ax9-";
    delims   = '{brhp_pkg::CH_COMMA, brhp_pkg::CH_AMP, brhp_pkg::CH_SEMI};
    kind     = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) hdr_chars.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4))
          hdr_chars.push_back(junk_set[$urandom_range(junk_set.len() - 1)]);
      end
      add_text("bytes=");
      if ($urandom_range(7) != 0) add_digits();
      if ($urandom_range(9) != 0) hdr_chars.push_back(brhp_pkg::CH_DASH);
      if ($urandom_range(3) != 0) add_digits();
      if ($urandom_range(3) == 0) begin
        hdr_chars.push_back(delims[$urandom_range(2)]);
        repeat ($urandom_range(0, 4)) hdr_chars.push_back(8'($urandom_range(255)));
      end
      if (kind >= 75) begin
        if ($urandom_range(1) == 0) begin
          repeat ($urandom_range(1, 3)) if (hdr_chars.size() > 1) void'(hdr_chars.pop_back());
        end else begin
          hdr_chars[$urandom_range(hdr_chars.size() - 1)] = 8'($urandom_range(255));
        end
      end
    end
  endtask

  task automatic run_random_headers(input int unsigned min_chars, input int unsigned min_hdrs);
    int unsigned chars;
    int unsigned hdrs;
    chars = 0;
    hdrs  = 0;
    while (chars < min_chars || hdrs < min_hdrs) begin
      make_random_header();
      chars += hdr_chars.size();
      hdrs++;
      send_header();
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_length(63'd1000);
    send_text("bytes=0-499");
    send_text("bytes=500-");
    send_text("bytes=-500");
    send_text("xbytes=1-2");
    send_text("bybytes=3-4");
    send_text("abc");
    add_text("a");
    hdr_chars.push_back(brhp_pkg::CH_NUL);
    send_text("bytes=1-2");
    send_text("bytes=1x");
    send_text("bytes=1--2");
    send_text("bytes=1-2,3-4");
    send_text("bytes=5-&zz");
    add_text("bytes=7-9;");
    hdr_chars.push_back(8'hff);
    send_header();
    send_text("bytes=");
    send_text("bytes=12");
    send_text("bytes=9-3");
    send_text("bytes=9223372036854775807-9223372036854775807");
    send_text("bytes=9223372036854775808-");
    send_text("bytes=0-92233720368547758070");
    add_text("bytes=");
    hdr_chars.push_back(8'hff);
    send_text("1-2");
    send_text("b");
    set_length('0);
    send_text("bytes=5-");
    send_text("bytes=0-0");
    set_length(63'd1);
    send_text("bytes=0-");
    set_length(POS_MAX);
    send_text("bytes=1-");
    send_text("bytes=-");
  endtask

  task automatic test_streaming();
    set_length(POS_BITS'({$urandom, $urandom}));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_headers(64, 4);
  endtask

  task automatic test_sender_gaps();
    set_length('0);
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    run_random_headers(64, 4);
  endtask

  task automatic test_receiver_stalls();
    set_length(POS_MAX);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_random_headers(64, 4);
  endtask

  task automatic test_mixed_idle();
    set_length(63'($urandom_range(1, 1000)));
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    run_random_headers(64, 4);
  endtask

  task automatic note_mismatch(input string what, input range_res_t exp_r,
                               input range_res_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected status %0d first %0d last %0d, got status %0d first %0d last %0d",
               what, exp_r.status, exp_r.rng_first, exp_r.rng_last,
               got_r.status, got_r.rng_first, got_r.rng_last);
    end
  endtask

  // result check and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_ranges.size() == 0) begin
        note_mismatch("unexpected word", '0,
                      '{res_ch.status, res_ch.range_first, res_ch.range_last});
      end else begin
        want = pending_ranges.pop_front();
        if (res_ch.status !== want.status || res_ch.range_first !== want.rng_first ||
            res_ch.range_last !== want.rng_last) begin
          note_mismatch("wrong word", want,
                        '{res_ch.status, res_ch.range_first, res_ch.range_last});
        end
      end
    end
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.text_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    content_len    = '0;
    clear_parse();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    drain();
    if (mismatches == 0 && pending_ranges.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
